// ===== sv/lpfc_pkg.sv =====
// Shared types and constants of the length-prefixed frame checker.
package lpfc_pkg;

    // Field widths
    localparam int DATA_W      = 8;
    localparam int LEN_BITS    = 24;
    localparam int CFG_W       = 24;
    localparam int CFG_IDX_W   = 2;
    localparam int LEN_FIELD_W = 32;
    localparam int TOT_W       = LEN_FIELD_W + 1;
    localparam int REGION_W    = 3;
    localparam int STATUS_W    = 3;
    // Result data bus: data byte and frame length, padded to whole bytes
    localparam int TDATA_W     = ((DATA_W + LEN_BITS + 7) / 8) * 8;

    // Start flag, two 4-byte lengths and end flag
    localparam logic [TOT_W-1:0]    OVERHEAD = TOT_W'(10);
    localparam logic [LEN_BITS-1:0] LEN_MASK = {LEN_BITS{1'b1}};

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_SOF_BYTE      = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_EOF_BYTE      = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME_LEN = CFG_IDX_W'(2);

    // Register reset values
    localparam logic [DATA_W-1:0] SOF_BYTE_RST      = DATA_W'(2);
    localparam logic [DATA_W-1:0] EOF_BYTE_RST      = DATA_W'(3);
    localparam logic [CFG_W-1:0]  MAX_FRAME_LEN_RST = CFG_W'(65536);

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_HLEN,
        PH_BLEN,
        PH_HEAD,
        PH_BODY,
        PH_END
    } phase_t;

    typedef enum logic [REGION_W-1:0] {
        RG_HUNT  = 3'd0,
        RG_START = 3'd1,
        RG_HLEN  = 3'd2,
        RG_BLEN  = 3'd3,
        RG_HEAD  = 3'd4,
        RG_BODY  = 3'd5,
        RG_END   = 3'd6
    } region_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_MORE      = 3'd0,
        ST_COMPLETE  = 3'd1,
        ST_START_ERR = 3'd2,
        ST_LEN_ERR   = 3'd3,
        ST_END_ERR   = 3'd4
    } status_t;

    typedef struct packed {
        logic [DATA_W-1:0] sof_byte;
        logic [DATA_W-1:0] eof_byte;
        logic [CFG_W-1:0]  max_frame_len;
    } cfg_t;

    typedef struct packed {
        logic [DATA_W-1:0]   data_byte;
        region_t             region;
        status_t             status;
        logic [LEN_BITS-1:0] frame_len;
    } result_t;

endpackage

// ===== sv/lpfc_cfg.sv =====
// Configuration registers of the frame checker.
module lpfc_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [lpfc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lpfc_pkg::CFG_W-1:0]     cfg_data,
    output lpfc_pkg::cfg_t                 cfg
);
    import lpfc_pkg::*;

    cfg_t cfg_reg;

    // Register writes; an unused index is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sof_byte      <= SOF_BYTE_RST;
            cfg_reg.eof_byte      <= EOF_BYTE_RST;
            cfg_reg.max_frame_len <= MAX_FRAME_LEN_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_SOF_BYTE:      cfg_reg.sof_byte      <= cfg_data[DATA_W-1:0];
                CFG_EOF_BYTE:      cfg_reg.eof_byte      <= cfg_data[DATA_W-1:0];
                CFG_MAX_FRAME_LEN: cfg_reg.max_frame_len <= cfg_data;
                default:           ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/lpfc_core.sv =====
// Frame layout state machine: classifies one byte per step and tracks lengths.
module lpfc_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic [lpfc_pkg::DATA_W-1:0] rx_byte,
    input  lpfc_pkg::cfg_t              cfg,
    output lpfc_pkg::result_t           result
);
    import lpfc_pkg::*;

    phase_t                 phase_reg, phase_next;
    logic [1:0]             cnt_reg, cnt_next;
    logic [LEN_FIELD_W-1:0] hdr_size_reg, hdr_size_next;
    logic [LEN_FIELD_W-1:0] pay_size_reg, pay_size_next;
    logic [LEN_BITS-1:0]    left_reg, left_next;
    logic [LEN_BITS-1:0]    total_reg, total_next;

    logic [LEN_FIELD_W-1:0] head_shift;
    logic [LEN_FIELD_W-1:0] body_shift;
    logic                   head_bad;
    logic                   body_bad;
    logic [TOT_W-1:0]       total_sum;
    logic [TOT_W-1:0]       limit;
    logic                   too_long;
    logic                   last_left;
    logic                   field_done;

    // Shared datapath terms
    always_comb
    begin
        head_shift = {hdr_size_reg[LEN_FIELD_W-DATA_W-1:0], rx_byte};
        body_shift = {pay_size_reg[LEN_FIELD_W-DATA_W-1:0], rx_byte};
        head_bad   = (head_shift == '0) || head_shift[LEN_FIELD_W-1];
        body_bad   = (body_shift == '0) || body_shift[LEN_FIELD_W-1];
        // head is already known positive here, so the sum cannot overflow 33 bits
        total_sum  = {1'b0, hdr_size_reg} + {1'b0, body_shift} + OVERHEAD;
        limit      = (TOT_W'(cfg.max_frame_len) > TOT_W'(LEN_MASK)) ?
                     TOT_W'(LEN_MASK) : TOT_W'(cfg.max_frame_len);
        too_long   = total_sum > limit;
        last_left  = (left_reg[LEN_BITS-1:1] == '0);
        field_done = (cnt_reg == 2'd3);
    end

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_HUNT:
            begin
                if (rx_byte == cfg.sof_byte)
                    phase_next = PH_HLEN;
            end
            PH_HLEN:
            begin
                if (field_done)
                    phase_next = head_bad ? PH_HUNT : PH_BLEN;
            end
            PH_BLEN:
            begin
                if (field_done)
                    phase_next = (body_bad || too_long) ? PH_HUNT : PH_HEAD;
            end
            PH_HEAD:
            begin
                if (last_left)
                    phase_next = PH_BODY;
            end
            PH_BODY:
            begin
                if (last_left)
                    phase_next = PH_END;
            end
            PH_END:  phase_next = PH_HUNT;
            default: phase_next = PH_HUNT;
        endcase
    end

    // Result fields and counter/length updates
    always_comb
    begin
        result.data_byte = rx_byte;
        result.region    = RG_HUNT;
        result.status    = ST_MORE;
        result.frame_len = '0;
        cnt_next         = cnt_reg;
        hdr_size_next    = hdr_size_reg;
        pay_size_next    = pay_size_reg;
        left_next        = left_reg;
        total_next       = total_reg;
        case (phase_reg)
            PH_HUNT:
            begin
                if (rx_byte == cfg.sof_byte)
                begin
                    result.region = RG_START;
                    cnt_next      = '0;
                    hdr_size_next = '0;
                    pay_size_next = '0;
                    left_next     = '0;
                end
                else
                begin
                    result.status = ST_START_ERR;
                end
            end
            PH_HLEN:
            begin
                result.region = RG_HLEN;
                hdr_size_next = head_shift;
                cnt_next      = cnt_reg + 2'd1;
                if (field_done && head_bad)
                    result.status = ST_LEN_ERR;
            end
            PH_BLEN:
            begin
                result.region = RG_BLEN;
                pay_size_next = body_shift;
                cnt_next      = cnt_reg + 2'd1;
                if (field_done)
                begin
                    if (body_bad || too_long)
                        result.status = ST_LEN_ERR;
                    else
                    begin
                        left_next  = hdr_size_reg[LEN_BITS-1:0];
                        total_next = total_sum[LEN_BITS-1:0];
                    end
                end
            end
            PH_HEAD:
            begin
                result.region = RG_HEAD;
                left_next     = last_left ? pay_size_reg[LEN_BITS-1:0] :
                                left_reg - LEN_BITS'(1);
            end
            PH_BODY:
            begin
                result.region = RG_BODY;
                left_next     = last_left ? '0 : left_reg - LEN_BITS'(1);
            end
            PH_END:
            begin
                result.region = RG_END;
                if (rx_byte == cfg.eof_byte)
                begin
                    result.status    = ST_COMPLETE;
                    result.frame_len = total_reg;
                end
                else
                begin
                    result.status = ST_END_ERR;
                end
            end
            default: ;
        endcase
    end

    // State registers, advanced once per byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HUNT;
            cnt_reg      <= '0;
            hdr_size_reg <= '0;
            pay_size_reg <= '0;
            left_reg     <= '0;
            total_reg    <= '0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            cnt_reg      <= cnt_next;
            hdr_size_reg <= hdr_size_next;
            pay_size_reg <= pay_size_next;
            left_reg     <= left_next;
            total_reg    <= total_next;
        end
    end

endmodule

// ===== sv/lpfc_out.sv =====
// Result register holding one classified byte until the receiver takes it.
module lpfc_out (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  lpfc_pkg::result_t result,
    input  logic              m_tready,
    output logic              m_tvalid,
    output lpfc_pkg::result_t held
);
    import lpfc_pkg::*;

    logic    valid_reg;
    result_t held_reg;

    // Valid flag: set on load, cleared once the request is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (m_tready)
            valid_reg <= 1'b0;
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (load)
            held_reg <= result;
    end

    assign m_tvalid = valid_reg;
    assign held     = held_reg;

endmodule

// ===== sv/length_prefixed_frame_checker.sv =====
// Top level of the length-prefixed, flag-delimited frame checker.
//
// Usage:
//   s_* carries received bytes, one per request. m_* returns one request per
//   byte: the byte, its frame region, a status and, on a completed frame, the
//   total frame length (head + body + 10 bytes of overhead).
//   cfg_wr_en/cfg_index/cfg_data write the start flag byte (0), the end flag
//   byte (1) and the maximum frame length (2); write only while no bytes are
//   in flight.
// Pipeline and throughput:
//   An accepted byte waits in the input register and is classified into the
//   result register when the pipeline advances, which raises m_tvalid. One
//   byte per cycle is sustained while m_tready stays high; the input register
//   and the result register form a two-stage pipeline.
// Reset:
//   rst_n clears the pipeline, sets the registers to 2, 3 and 65536 and puts
//   the checker in start-flag hunt.
// Stall:
//   While m_tready is low the result is held; one more byte can be taken into
//   the input register, after which s_tready drops until the result leaves.
module length_prefixed_frame_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] rx_byte
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [lpfc_pkg::TDATA_W-1:0]   m_tdata,   // [7:0] data_byte, [31:8] frame_len
    output logic [7:0]                     m_tuser,   // [2:0] region, [5:3] status, [7:6] zero
    input  logic                           cfg_wr_en,
    input  logic [lpfc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lpfc_pkg::CFG_W-1:0]     cfg_data
);
    import lpfc_pkg::*;

    logic              in_valid_reg;
    logic [DATA_W-1:0] in_byte_reg;
    logic              advance;
    logic              step;
    cfg_t              cfg;
    result_t           result;
    result_t           held;

    // Pipeline moves when the result register is free or being emptied
    assign advance  = !m_tvalid || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_byte_reg <= s_tdata;
    end

    lpfc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lpfc_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .rx_byte (in_byte_reg),
        .cfg     (cfg),
        .result  (result)
    );

    lpfc_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (step),
        .result   (result),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .held     (held)
    );

    // Output packing
    assign m_tdata = TDATA_W'({held.frame_len, held.data_byte});
    assign m_tuser = {2'b00, held.status, held.region};

`ifndef ASSERT_OFF
    // A frame length is only reported with a completed frame
    a_len_only_complete: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (held.status != ST_COMPLETE) |-> (held.frame_len == '0))
        else $error("frame length reported without a completed frame");

    // Completion is only ever signalled on the end flag byte
    a_complete_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (held.status == ST_COMPLETE) |-> (held.region == RG_END))
        else $error("completion outside the end region");

    // Input stalls only when both pipeline stages are full and blocked
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && m_tvalid && !m_tready)
        else $error("input stalled without a full pipeline");

    // A byte taken by the core always appears in the result register next cycle
    a_step_loads: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> m_tvalid)
        else $error("classified byte lost");
`endif

endmodule
